@@ rtl/core/rmfs_pkg.sv @@
`timescale 1ns / 1ps

package rmfs_pkg;

  // Frame geometry defaults
  localparam int ROWS_DEFAULT    = 64;
  localparam int COLUMNS_DEFAULT = 64;
  localparam int PLANES          = 3;

  // Field widths, fixed by the command and result formats
  localparam int CMD_W      = 2;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int COLOR_W    = 3;
  localparam int DATA_W     = 64;
  localparam int ROW_ADDR_W = 5;

  // Plane order inside a store word and inside the colour mask
  localparam int PLANE_RED   = 0;
  localparam int PLANE_GREEN = 1;
  localparam int PLANE_BLUE  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_PIXEL   = 2'd0,
    CMD_CLEAR_PIXEL = 2'd1,
    CMD_WRITE_ROW   = 2'd2,
    CMD_SCAN_ROW    = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_READ_TOP,
    ST_WRITE,
    ST_READ_BOTTOM,
    ST_LOAD,
    ST_SHIFT
  } state_t;

endpackage

@@ rtl/core/rmfs_cmd_if.sv @@
`timescale 1ns / 1ps

interface rmfs_cmd_if
  import rmfs_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   column;
  logic [COLOR_W-1:0] color;
  logic [DATA_W-1:0]  row_data;

  modport source (output valid, command, row, column, color, row_data, input ready);
  modport sink   (input valid, command, row, column, color, row_data, output ready);
endinterface

@@ rtl/core/rmfs_scan_if.sv @@
`timescale 1ns / 1ps

interface rmfs_scan_if
  import rmfs_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [ROW_ADDR_W-1:0] row_address;
  logic [COL_W-1:0]      column_index;
  logic                  top_red;
  logic                  top_green;
  logic                  top_blue;
  logic                  bottom_red;
  logic                  bottom_green;
  logic                  bottom_blue;
  logic                  last_of_row;

  modport source (output valid, row_address, column_index, top_red, top_green, top_blue,
                  bottom_red, bottom_green, bottom_blue, last_of_row, input ready);
  modport sink   (input valid, row_address, column_index, top_red, top_green, top_blue,
                  bottom_red, bottom_green, bottom_blue, last_of_row, output ready);
endinterface

@@ rtl/core/rmfs_store.sv @@
`timescale 1ns / 1ps

// Frame store: one word per frame row holding all colour planes.
// A row never written since reset reads as zero through its valid bit.
module rmfs_store
  import rmfs_pkg::*;
#(
  parameter int ROWS   = ROWS_DEFAULT,
  parameter int WORD_W = PLANES * COLUMNS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [$clog2(ROWS)-1:0]   rd_addr,
  output logic [WORD_W-1:0]         rd_data,
  input  logic                      wr_en,
  input  logic [$clog2(ROWS)-1:0]   wr_addr,
  input  logic [WORD_W-1:0]         wr_data
);

  logic [WORD_W-1:0] mem [ROWS];
  logic [ROWS-1:0]   valid;
  logic [WORD_W-1:0] rd_word;
  logic              rd_live;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_word <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      rd_live <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_live <= valid[rd_addr];
    end
  end

  assign rd_data = rd_live ? rd_word : '0;

endmodule

@@ rtl/core/rgb_matrix_frame_store_scanout_unit.sv @@
`timescale 1ns / 1ps

// Frame store and row-pair scan-out for an RGB LED matrix of ROWS by COLUMNS
// pixels in three colour planes, cleared at reset. Commands arrive on cmd one
// at a time; cmd.ready is high only while the unit is idle. Set pixel, clear
// pixel and write row are read-modify-write on the row store, each going
// through accept, read and write back. A scan command folds the row into a
// row pair by taking ROWS/2 off while it is at least ROWS/2, then reads the
// top and bottom rows into the shift registers, then streams COLUMNS results
// on scan, one per cycle when scan.ready stays high, from column COLUMNS-1
// down to 0; the last carries last_of_row. The results leave through
// per-plane shift registers, one column bit per cycle while scan.ready is
// high. Commands with a row outside the store, and pixel commands with a
// column outside the row, change nothing.
module rgb_matrix_frame_store_scanout_unit
  import rmfs_pkg::*;
#(
  parameter int ROWS    = ROWS_DEFAULT,
  parameter int COLUMNS = COLUMNS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  rmfs_cmd_if.sink     cmd,
  rmfs_scan_if.source  scan
);

  localparam int AW        = $clog2(ROWS);
  localparam int HALF_ROWS = ROWS / 2;
  localparam int WORD_W    = PLANES * COLUMNS;

  state_t state, state_next;

  // Latched command
  cmd_code_t          op;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   column;
  logic [COLOR_W-1:0] color;
  logic [COLUMNS-1:0] data;

  // Scan datapath: row pair, column counter, per-plane shift registers
  logic [ROW_W-1:0]                pair;
  logic [COL_W-1:0]                count;
  logic [PLANES-1:0][COLUMNS-1:0]  top_sr;
  logic [PLANES-1:0][COLUMNS-1:0]  bot_sr;

  // Store port
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              wr_en;
  logic [WORD_W-1:0] wr_data;

  logic               row_ok;
  logic               col_ok;
  logic               pair_high;
  logic [COLUMNS-1:0] col_hot;
  logic               cmd_xfer;
  logic               scan_xfer;

  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign scan_xfer = scan.valid && scan.ready;
  assign row_ok    = 32'(row) < ROWS;
  assign col_ok    = 32'(column) < COLUMNS;
  assign pair_high = 32'(pair) >= HALF_ROWS;

  rmfs_store #(
    .ROWS   (ROWS),
    .WORD_W (WORD_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (AW'(row)),
    .wr_data (wr_data)
  );

  // Decode the pixel column to a one-hot row mask
  always_comb begin
    for (int i = 0; i < COLUMNS; i++) begin
      col_hot[i] = 32'(column) == i;
    end
  end

  // Merge the command into the row just read back
  always_comb begin
    for (int p = 0; p < PLANES; p++) begin
      if (op == CMD_WRITE_ROW) begin
        wr_data[p*COLUMNS +: COLUMNS] = color[p] ? data : rd_data[p*COLUMNS +: COLUMNS];
      end else if (op == CMD_SET_PIXEL && color != '0) begin
        wr_data[p*COLUMNS +: COLUMNS] = rd_data[p*COLUMNS +: COLUMNS] |
                                        (color[p] ? col_hot : '0);
      end else begin
        wr_data[p*COLUMNS +: COLUMNS] = rd_data[p*COLUMNS +: COLUMNS] & ~col_hot;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_xfer) begin
          state_next = (cmd_code_t'(cmd.command) == CMD_SCAN_ROW) ? ST_REDUCE : ST_READ_TOP;
        end
      end
      ST_REDUCE: begin
        if (!pair_high) begin
          state_next = ST_READ_TOP;
        end
      end
      ST_READ_TOP:    state_next = (op == CMD_SCAN_ROW) ? ST_READ_BOTTOM : ST_WRITE;
      ST_WRITE:       state_next = ST_IDLE;
      ST_READ_BOTTOM: state_next = ST_LOAD;
      ST_LOAD:        state_next = ST_SHIFT;
      ST_SHIFT: begin
        if (scan_xfer && count == '0) begin
          state_next = ST_IDLE;
        end
      end
      default:        state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    cmd.ready  = 1'b0;
    scan.valid = 1'b0;
    wr_en      = 1'b0;
    rd_addr    = AW'(row);
    case (state)
      ST_IDLE:        cmd.ready  = 1'b1;
      ST_READ_TOP:    rd_addr    = (op == CMD_SCAN_ROW) ? AW'(pair) : AW'(row);
      ST_WRITE:       wr_en      = row_ok && (op == CMD_WRITE_ROW || col_ok);
      ST_READ_BOTTOM: rd_addr    = AW'(32'(pair) + HALF_ROWS);
      ST_SHIFT:       scan.valid = 1'b1;
      default:        ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the command, fold the scan row, load and advance the shift registers
  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      op     <= cmd_code_t'(cmd.command);
      row    <= cmd.row;
      column <= cmd.column;
      color  <= cmd.color;
      data   <= cmd.row_data[COLUMNS-1:0];
      pair   <= cmd.row;
    end
    if (state == ST_REDUCE && pair_high) begin
      pair <= ROW_W'(7'(pair) - 7'(HALF_ROWS));
    end
    if (state == ST_READ_BOTTOM) begin
      for (int p = 0; p < PLANES; p++) begin
        top_sr[p] <= rd_data[p*COLUMNS +: COLUMNS];
      end
    end
    if (state == ST_LOAD) begin
      for (int p = 0; p < PLANES; p++) begin
        bot_sr[p] <= rd_data[p*COLUMNS +: COLUMNS];
      end
      count <= COL_W'(COLUMNS - 1);
    end
    if (scan_xfer) begin
      for (int p = 0; p < PLANES; p++) begin
        top_sr[p] <= top_sr[p] << 1;
        bot_sr[p] <= bot_sr[p] << 1;
      end
      count <= count - 1'b1;
    end
  end

  // Each transfer shows the top bit of every shift register
  assign scan.row_address  = pair[ROW_ADDR_W-1:0];
  assign scan.column_index = count;
  assign scan.top_red      = top_sr[PLANE_RED][COLUMNS-1];
  assign scan.top_green    = top_sr[PLANE_GREEN][COLUMNS-1];
  assign scan.top_blue     = top_sr[PLANE_BLUE][COLUMNS-1];
  assign scan.bottom_red   = bot_sr[PLANE_RED][COLUMNS-1];
  assign scan.bottom_green = bot_sr[PLANE_GREEN][COLUMNS-1];
  assign scan.bottom_blue  = bot_sr[PLANE_BLUE][COLUMNS-1];
  assign scan.last_of_row  = count == '0;

  // Commands and results never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ready && scan.valid))
    else $error("command taken while a scan is in flight");

  // Columns step down by one between transfers of a scan
  a_column_step: assert property (@(posedge clk) disable iff (rst)
    scan.valid && scan.ready && !scan.last_of_row |=>
      scan.valid && scan.column_index == $past(scan.column_index) - 1'b1)
    else $error("scan column did not step down by one");

  // The final column hands control back to the command side
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    scan.valid && scan.ready && scan.last_of_row |=> cmd.ready && !scan.valid)
    else $error("unit not idle after the last column");

endmodule
